### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define RSI_ASSERT_NEVER(lbl, expr, msg) `RSI_ASSERT(lbl, !(expr), msg)
`else
`define RSI_ASSERT(lbl, prop, msg)
`define RSI_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// Ray and sphere intersection package
// Widths, transaction types and helper functions shared by the pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Fixed point format and derived widths.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int RADIUS_W  = 31;
  localparam int HALF_W    = DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = 2 * PROD_W;
  localparam int ROOT_W    = PROD_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QMAG_W    = PROD_W + 1;
  localparam int QUOT_W    = DATA_W - 1;
  localparam int NUM_W     = QMAG_W + FRAC_BITS;
  localparam int DSH_W     = QMAG_W + QUOT_W - 1;
  localparam int CMP_W     = QMAG_W + QUOT_W;

  // Pipeline depth: front end, square root, root set-up, divider, back end.
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + 2 + QUOT_W + BACK_STAGES;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << FRAC_BITS;

  typedef logic signed [DATA_W-1:0] fix_t;

  typedef struct packed {
    fix_t t_min;
    fix_t t_max;
  } range_t;

  typedef struct packed {
    fix_t   origin_x;
    fix_t   origin_y;
    fix_t   origin_z;
    fix_t   dir_x;
    fix_t   dir_y;
    fix_t   dir_z;
    range_t rng;
  } ray_t;

  // Quadratic terms carried alongside the square root.
  typedef struct packed {
    logic              miss;
    logic              bneg;
    logic              cneg;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] bmag;
    logic [PROD_W-1:0] cmag;
    range_t            rng;
  } side_t;

  // One digit step of the square root.
  typedef struct packed {
    logic [WIDE_W-1:0] rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One bit step of a restoring divider.
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [DSH_W-1:0]  dsh;
    logic [QUOT_W-1:0] q;
  } div_t;

  // Flags carried alongside the dividers.
  typedef struct packed {
    logic   miss;
    logic   qzero;
    logic   neg0;
    logic   neg1;
    logic   sat0;
    logic   sat1;
    range_t rng;
  } tail_t;

  // Magnitude of a signed value; the most negative value maps to 2^(DATA_W-1).
  function automatic logic [DATA_W-1:0] mag_of(fix_t x);
    logic [DATA_W-1:0] u;
    u = x;
    return u[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

  // Apply a sign to a magnitude and saturate positive overflow.
  function automatic fix_t to_t(logic neg, logic [DATA_W-1:0] mag);
    fix_t r;
    if (neg) begin
      r = fix_t'(~mag + 1'b1);
    end else if (mag[DATA_W-1]) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = fix_t'(mag);
    end
    return r;
  endfunction

endpackage

### sv/rsi_front.sv
// ----------------------------------------------------------------------------
// Quadratic front end
// Forms A, B and C from the ray and the radius, then the discriminant.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  ray_t                    ray_i,
  input  logic [RADIUS_W-1:0]     radius_i,
  output logic                    vld_o,
  output side_t                   side_o,
  output logic [WIDE_W-1:0]       disc_o
);

  fix_t              o_c [3];
  fix_t              d_c [3];
  logic [DATA_W-1:0] om_c [3];
  logic [DATA_W-1:0] dm_c [3];

  logic [6:0]        vld_r;

  logic [PROD_W-1:0] dd1_r [3];
  logic [PROD_W-1:0] oo1_r [3];
  logic [PROD_W-1:0] do1_r [3];
  logic [2:0]        sx1_r;
  logic [PROD_W-1:0] r21_r;
  range_t            rng1_r;

  logic [PROD_W-1:0] a2_r, oo2_r, bp2_r, bn2_r, r22_r;
  range_t            rng2_r;

  logic [PROD_W:0]   bpn_c, bnp_c, ocr_c, cro_c;
  side_t             side3_r;

  logic [PROD_W-1:0] bb00_r, bb01_r, bb11_r, ac00_r, ac01_r, ac10_r, ac11_r;
  side_t             side4_r;

  logic [WIDE_W-1:0] bbcat5_r, accat5_r;
  logic [QMAG_W-1:0] bbmid5_r, acmid5_r;
  side_t             side5_r;

  logic [WIDE_W-1:0] bb6_r, ac6_r;
  side_t             side6_r;

  logic [WIDE_W-1:0] sum_c;
  logic [WIDE_W:0]   dif_c;
  logic [WIDE_W-1:0] disc7_r;
  side_t             side7_nxt;
  side_t             side7_r;

  // Split the ray into component arrays and magnitudes.
  always_comb begin
    o_c[0] = ray_i.origin_x;
    o_c[1] = ray_i.origin_y;
    o_c[2] = ray_i.origin_z;
    d_c[0] = ray_i.dir_x;
    d_c[1] = ray_i.dir_y;
    d_c[2] = ray_i.dir_z;
    for (int i = 0; i < 3; i++) begin
      om_c[i] = mag_of(o_c[i]);
      dm_c[i] = mag_of(d_c[i]);
    end
  end

  // Valid bits travel down the seven stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  // Stage 1: the component products, each 32 by 32 bits.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd1_r[i] <= PROD_W'(dm_c[i]) * PROD_W'(dm_c[i]);
      oo1_r[i] <= PROD_W'(om_c[i]) * PROD_W'(om_c[i]);
      do1_r[i] <= PROD_W'(dm_c[i]) * PROD_W'(om_c[i]);
      sx1_r[i] <= d_c[i][DATA_W-1] ^ o_c[i][DATA_W-1];
    end
    r21_r  <= PROD_W'(radius_i) * PROD_W'(radius_i);
    rng1_r <= ray_i.rng;
  end

  // Stage 2: dot products, with B split into positive and negative parts.
  always_ff @(posedge clk) begin
    a2_r   <= dd1_r[0] + dd1_r[1] + dd1_r[2];
    oo2_r  <= oo1_r[0] + oo1_r[1] + oo1_r[2];
    bp2_r  <= (sx1_r[0] ? '0 : do1_r[0]) + (sx1_r[1] ? '0 : do1_r[1])
            + (sx1_r[2] ? '0 : do1_r[2]);
    bn2_r  <= (sx1_r[0] ? do1_r[0] : '0) + (sx1_r[1] ? do1_r[1] : '0)
            + (sx1_r[2] ? do1_r[2] : '0);
    r22_r  <= r21_r;
    rng2_r <= rng1_r;
  end

  // Stage 3: sign and magnitude of B and of C.
  assign bpn_c = {1'b0, bp2_r} - {1'b0, bn2_r};
  assign bnp_c = {1'b0, bn2_r} - {1'b0, bp2_r};
  assign ocr_c = {1'b0, oo2_r} - {1'b0, r22_r};
  assign cro_c = {1'b0, r22_r} - {1'b0, oo2_r};

  always_ff @(posedge clk) begin
    side3_r.miss <= (a2_r == '0);
    side3_r.bneg <= bpn_c[PROD_W];
    side3_r.cneg <= ocr_c[PROD_W];
    side3_r.a    <= a2_r;
    side3_r.bmag <= bpn_c[PROD_W] ? bnp_c[PROD_W-1:0] : bpn_c[PROD_W-1:0];
    side3_r.cmag <= ocr_c[PROD_W] ? cro_c[PROD_W-1:0] : ocr_c[PROD_W-1:0];
    side3_r.rng  <= rng2_r;
  end

  // Stage 4: half-word partial products of B*B and A*C.
  always_ff @(posedge clk) begin
    bb00_r  <= PROD_W'(side3_r.bmag[HALF_W-1:0]) * PROD_W'(side3_r.bmag[HALF_W-1:0]);
    bb01_r  <= PROD_W'(side3_r.bmag[HALF_W-1:0]) * PROD_W'(side3_r.bmag[PROD_W-1:HALF_W]);
    bb11_r  <= PROD_W'(side3_r.bmag[PROD_W-1:HALF_W])
             * PROD_W'(side3_r.bmag[PROD_W-1:HALF_W]);
    ac00_r  <= PROD_W'(side3_r.a[HALF_W-1:0]) * PROD_W'(side3_r.cmag[HALF_W-1:0]);
    ac01_r  <= PROD_W'(side3_r.a[HALF_W-1:0]) * PROD_W'(side3_r.cmag[PROD_W-1:HALF_W]);
    ac10_r  <= PROD_W'(side3_r.a[PROD_W-1:HALF_W]) * PROD_W'(side3_r.cmag[HALF_W-1:0]);
    ac11_r  <= PROD_W'(side3_r.a[PROD_W-1:HALF_W])
             * PROD_W'(side3_r.cmag[PROD_W-1:HALF_W]);
    side4_r <= side3_r;
  end

  // Stage 5: outer partials side by side, cross terms summed.
  always_ff @(posedge clk) begin
    bbcat5_r <= {bb11_r, bb00_r};
    accat5_r <= {ac11_r, ac00_r};
    bbmid5_r <= {bb01_r, 1'b0};
    acmid5_r <= {1'b0, ac01_r} + {1'b0, ac10_r};
    side5_r  <= side4_r;
  end

  // Stage 6: full 128-bit products.
  always_ff @(posedge clk) begin
    bb6_r   <= bbcat5_r + (WIDE_W'(bbmid5_r) << HALF_W);
    ac6_r   <= accat5_r + (WIDE_W'(acmid5_r) << HALF_W);
    side6_r <= side5_r;
  end

  // Stage 7: discriminant; a negative one marks a miss.
  assign sum_c = bb6_r + ac6_r;
  assign dif_c = {1'b0, bb6_r} - {1'b0, ac6_r};

  always_comb begin
    side7_nxt      = side6_r;
    side7_nxt.miss = side6_r.miss | (!side6_r.cneg & dif_c[WIDE_W]);
  end

  always_ff @(posedge clk) begin
    disc7_r <= side6_r.cneg ? sum_c : dif_c[WIDE_W-1:0];
    side7_r <= side7_nxt;
  end

  assign vld_o  = vld_r[6];
  assign side_o = side7_r;
  assign disc_o = disc7_r;

endmodule

### sv/rsi_sqrt_step.sv
// ----------------------------------------------------------------------------
// Square root step
// One registered digit of the restoring integer square root.
// ----------------------------------------------------------------------------
module rsi_sqrt_step import rsi_pkg::*; (
  input  logic  clk,
  input  sqrt_t st_i,
  output sqrt_t st_o
);

  logic [REM_W-1:0] rem_sh_c;
  logic [REM_W-1:0] trial_c;
  logic [REM_W:0]   dif_c;
  sqrt_t            st_nxt;
  sqrt_t            st_r;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh_c    = {st_i.rem[REM_W-3:0], st_i.rad[WIDE_W-1 -: 2]};
    trial_c     = {st_i.root, 2'b01};
    dif_c       = {1'b0, rem_sh_c} - {1'b0, trial_c};
    st_nxt.rad  = {st_i.rad[WIDE_W-3:0], 2'b00};
    st_nxt.rem  = dif_c[REM_W] ? rem_sh_c : dif_c[REM_W-1:0];
    st_nxt.root = {st_i.root[ROOT_W-2:0], !dif_c[REM_W]};
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st_o = st_r;

endmodule

### sv/rsi_div_step.sv
// ----------------------------------------------------------------------------
// Divider step
// One registered quotient bit of a restoring divider.
// ----------------------------------------------------------------------------
module rsi_div_step import rsi_pkg::*; (
  input  logic clk,
  input  div_t st_i,
  output div_t st_o
);

  logic [DSH_W:0] dif_c;
  div_t           st_nxt;
  div_t           st_r;

  // Subtract the shifted divisor where it fits, then halve it.
  always_comb begin
    dif_c      = {1'b0, DSH_W'(st_i.rem)} - {1'b0, st_i.dsh};
    st_nxt.rem = dif_c[DSH_W] ? st_i.rem : dif_c[NUM_W-1:0];
    st_nxt.dsh = st_i.dsh >> 1;
    st_nxt.q   = {st_i.q[QUOT_W-2:0], !dif_c[DSH_W]};
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st_o = st_r;

endmodule

### sv/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// Ray and sphere intersection
// Tests a ray against a sphere at the origin and returns the nearest root.
//
//   Channel  Handshake            Contents
//   in_      start / busy         ray origin, direction, t range
//   out_     out_strobe           hit flag and t_hit
//   cfg_     cfg_valid/cfg_ready  sphere radius
//
// One ray is taken in every cycle; busy stays low.
// Each result passes these registered stages after its ray is accepted: seven front
// stages, one per root bit of the 64-bit square root, two set-up stages,
// one per quotient bit of the two 31-bit dividers, and three back stages.
// Synchronous reset clears every valid bit and sets the radius to 1.0.
// The pipeline never stalls, as results cannot be held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_intersect import rsi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fix_t                in_origin_x,
  input  fix_t                in_origin_y,
  input  fix_t                in_origin_z,
  input  fix_t                in_dir_x,
  input  fix_t                in_dir_y,
  input  fix_t                in_dir_z,
  input  fix_t                in_t_min,
  input  fix_t                in_t_max,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_sphere_radius,
  output logic                out_strobe,
  output logic                out_hit,
  output fix_t                out_t_hit
);

  logic [RADIUS_W-1:0] radius_r;
  ray_t                ray_c;
  logic                front_vld;
  side_t               front_side;
  logic [WIDE_W-1:0]   front_disc;

  sqrt_t               sq_seed;
  sqrt_t               sq_st [ROOT_W];
  logic [ROOT_W-1:0]   sq_vld_r;
  side_t               sq_side_r [ROOT_W];

  logic                q_vld_r;
  side_t               q_side_r;
  logic [QMAG_W-1:0]   qmag_r;

  logic [NUM_W-1:0]    n0_c, n1_c;
  logic [QMAG_W-1:0]   d0_c;
  logic                sat0_c, sat1_c;
  logic                s_vld_r;
  tail_t               s_tail_r;
  div_t                s_div0_r, s_div1_r;

  div_t                dv0_st [QUOT_W];
  div_t                dv1_st [QUOT_W];
  logic [QUOT_W-1:0]   dv_vld_r;
  tail_t               dv_tail_r [QUOT_W];

  tail_t               last_tail;
  logic [DATA_W-1:0]   mag0_c, mag1_c;
  logic                f1_vld_r;
  logic                f1_miss_r;
  range_t              f1_rng_r;
  fix_t                f1_t0_r, f1_t1_r;

  logic                f2_vld_r;
  logic                f2_miss_r;
  range_t              f2_rng_r;
  fix_t                f2_lo_r, f2_hi_r;

  logic                hit_c;
  logic                out_strobe_r;
  logic                out_hit_r;
  fix_t                out_t_hit_r;

  // The pipeline takes a transaction in every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Radius register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_sphere_radius;
    end
  end

  // Gather the input transaction.
  always_comb begin
    ray_c.origin_x  = in_origin_x;
    ray_c.origin_y  = in_origin_y;
    ray_c.origin_z  = in_origin_z;
    ray_c.dir_x     = in_dir_x;
    ray_c.dir_y     = in_dir_y;
    ray_c.dir_z     = in_dir_z;
    ray_c.rng.t_min = in_t_min;
    ray_c.rng.t_max = in_t_max;
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (start && !busy),
    .ray_i    (ray_c),
    .radius_i (radius_r),
    .vld_o    (front_vld),
    .side_o   (front_side),
    .disc_o   (front_disc)
  );

  // Square root chain, one root bit per stage.
  always_comb begin
    sq_seed.rad  = front_disc;
    sq_seed.rem  = '0;
    sq_seed.root = '0;
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      rsi_sqrt_step u_step (.clk(clk), .st_i(sq_seed), .st_o(sq_st[g]));
    end else begin : g_next
      rsi_sqrt_step u_step (.clk(clk), .st_i(sq_st[g-1]), .st_o(sq_st[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= '0;
    end else begin
      sq_vld_r <= {sq_vld_r[ROOT_W-2:0], front_vld};
    end
  end

  always_ff @(posedge clk) begin
    sq_side_r[0] <= front_side;
    for (int k = 1; k < ROOT_W; k++) begin
      sq_side_r[k] <= sq_side_r[k-1];
    end
  end

  // Stable form: the magnitude of Q is |B| plus the root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= sq_vld_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    q_side_r <= sq_side_r[ROOT_W-1];
    qmag_r   <= {1'b0, sq_side_r[ROOT_W-1].bmag} + {1'b0, sq_st[ROOT_W-1].root};
  end

  // Divider set-up with the saturation test for each quotient.
  assign n0_c   = {qmag_r, {FRAC_BITS{1'b0}}};
  assign n1_c   = NUM_W'({q_side_r.cmag, {FRAC_BITS{1'b0}}});
  assign d0_c   = {1'b0, q_side_r.a};
  assign sat0_c = CMP_W'(n0_c) >= {d0_c, {QUOT_W{1'b0}}};
  assign sat1_c = CMP_W'(n1_c) >= {qmag_r, {QUOT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s_tail_r.miss  <= q_side_r.miss;
    s_tail_r.qzero <= (qmag_r == '0);
    s_tail_r.neg0  <= !q_side_r.bneg;
    s_tail_r.neg1  <= q_side_r.cneg ^ !q_side_r.bneg;
    s_tail_r.sat0  <= sat0_c;
    s_tail_r.sat1  <= sat1_c;
    s_tail_r.rng   <= q_side_r.rng;
    s_div0_r.rem   <= n0_c;
    s_div0_r.dsh   <= {d0_c, {(QUOT_W-1){1'b0}}};
    s_div0_r.q     <= '0;
    s_div1_r.rem   <= n1_c;
    s_div1_r.dsh   <= {qmag_r, {(QUOT_W-1){1'b0}}};
    s_div1_r.q     <= '0;
  end

  // Two dividers side by side: t0 = Q/A and t1 = C/Q.
  for (genvar g = 0; g < QUOT_W; g++) begin : g_div
    if (g == 0) begin : g_first
      rsi_div_step u_div0 (.clk(clk), .st_i(s_div0_r), .st_o(dv0_st[g]));
      rsi_div_step u_div1 (.clk(clk), .st_i(s_div1_r), .st_o(dv1_st[g]));
    end else begin : g_next
      rsi_div_step u_div0 (.clk(clk), .st_i(dv0_st[g-1]), .st_o(dv0_st[g]));
      rsi_div_step u_div1 (.clk(clk), .st_i(dv1_st[g-1]), .st_o(dv1_st[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      dv_vld_r <= {dv_vld_r[QUOT_W-2:0], s_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    dv_tail_r[0] <= s_tail_r;
    for (int k = 1; k < QUOT_W; k++) begin
      dv_tail_r[k] <= dv_tail_r[k-1];
    end
  end

  // Back stage 1: signed, saturated roots.
  assign last_tail = dv_tail_r[QUOT_W-1];
  assign mag0_c = last_tail.sat0 ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, dv0_st[QUOT_W-1].q};
  assign mag1_c = last_tail.sat1 ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, dv1_st[QUOT_W-1].q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= dv_vld_r[QUOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    f1_miss_r <= last_tail.miss;
    f1_rng_r  <= last_tail.rng;
    f1_t0_r   <= last_tail.qzero ? '0 : to_t(last_tail.neg0, mag0_c);
    f1_t1_r   <= last_tail.qzero ? '0 : to_t(last_tail.neg1, mag1_c);
  end

  // Back stage 2: sort the roots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_miss_r <= f1_miss_r;
    f2_rng_r  <= f1_rng_r;
    f2_lo_r   <= (f1_t0_r > f1_t1_r) ? f1_t1_r : f1_t0_r;
    f2_hi_r   <= (f1_t0_r > f1_t1_r) ? f1_t0_r : f1_t1_r;
  end

  // Back stage 3: pick the nearest root inside the range.
  assign hit_c = !f2_miss_r
               && !(f2_lo_r > f2_rng_r.t_max || f2_hi_r < f2_rng_r.t_min)
               && (f2_lo_r >= f2_rng_r.t_min || f2_hi_r <= f2_rng_r.t_max);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= hit_c;
    if (!hit_c) begin
      out_t_hit_r <= '0;
    end else if (f2_lo_r >= f2_rng_r.t_min) begin
      out_t_hit_r <= f2_lo_r;
    end else begin
      out_t_hit_r <= f2_hi_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;
  assign out_t_hit  = out_t_hit_r;

  // Every result belongs to a transaction accepted earlier.
  `RSI_ASSERT(a_strobe_after_accept, out_strobe |-> $past(start && !busy, LATENCY), "result without transaction")
  // The sort leaves the lower root first.
  `RSI_ASSERT_NEVER(a_roots_sorted, f2_vld_r && (f2_lo_r > f2_hi_r), "roots out of order")
  // A reported hit lies inside the range of its own transaction.
  `RSI_ASSERT(a_hit_in_range, out_strobe && out_hit |-> (out_t_hit >= $past(f2_rng_r.t_min)) && (out_t_hit <= $past(f2_rng_r.t_max)), "hit outside range")

endmodule

### tb/sv/ray_sphere_intersect_tb.sv
// ----------------------------------------------------------------------------
// Ray and sphere intersection testbench
// Drives rays into the intersection pipeline under several sphere radii,
// predicts each hit flag and t_hit with an independent fixed-point model and
// checks every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint T_SAT = 64'sd2147483648;

  typedef struct {
    logic hit;
    fix_t t_hit;
  } hit_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ray_t                ray_drv;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RADIUS_W-1:0] cfg_sphere_radius;
  logic                out_strobe;
  logic                out_hit;
  fix_t                out_t_hit;

  hit_result_t         pending_hits[$];
  logic [RADIUS_W-1:0] radius_model;
  int                  error_count;
  int                  quiet_cycles;
  bit                  idle_on;

  ray_sphere_intersect DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_origin_x       (ray_drv.origin_x),
    .in_origin_y       (ray_drv.origin_y),
    .in_origin_z       (ray_drv.origin_z),
    .in_dir_x          (ray_drv.dir_x),
    .in_dir_y          (ray_drv.dir_y),
    .in_dir_z          (ray_drv.dir_z),
    .in_t_min          (ray_drv.rng.t_min),
    .in_t_max          (ray_drv.rng.t_max),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sphere_radius (cfg_sphere_radius),
    .out_strobe        (out_strobe),
    .out_hit           (out_hit),
    .out_t_hit         (out_t_hit)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude of a signed coordinate, widened so the most negative value fits.
  function automatic logic [63:0] abs_wide(fix_t x);
    longint v;
    v = x;
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Clamp a quotient magnitude to 2^31, then apply its sign and saturate.
  function automatic longint signed_root(bit neg, logic [127:0] quo);
    longint m;
    m = (quo >= 128'(T_SAT)) ? T_SAT : longint'(quo[31:0]);
    if (neg) return -m;
    return (m >= T_SAT) ? T_SAT - 1 : m;
  endfunction

  // Nearest root of |o + t*d| = r inside [t_min, t_max], or a miss.
  function automatic hit_result_t predict_intersection(ray_t r, logic [RADIUS_W-1:0] rad);
    hit_result_t res;
    fix_t        o[3];
    fix_t        d[3];
    logic [63:0] dm, om, a, oo, bp, bn, bmag, cmag, r2, root, cand;
    logic [127:0] bb, ac, disc;
    logic [64:0] qmag;
    bit          bneg, cneg, qneg;
    longint      t0, t1, tt, tmin, tmax;
    res.hit = 1'b0;
    res.t_hit = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
    tmin = r.rng.t_min;
    tmax = r.rng.t_max;
    a = 0; oo = 0; bp = 0; bn = 0;
    for (int i = 0; i < 3; i++) begin
      dm = abs_wide(d[i]);
      om = abs_wide(o[i]);
      a  += dm * dm;
      oo += om * om;
      if (d[i][DATA_W-1] != o[i][DATA_W-1]) bn += dm * om;
      else bp += dm * om;
    end
    // A zero direction never meets the sphere.
    if (a == 0) return res;
    bneg = bn > bp;
    bmag = bneg ? bn - bp : bp - bn;
    r2   = 64'(rad) * 64'(rad);
    cneg = r2 > oo;
    cmag = cneg ? r2 - oo : oo - r2;
    bb   = 128'(bmag) * 128'(bmag);
    ac   = 128'(a) * 128'(cmag);
    if (cneg) disc = bb + ac;
    else begin
      // Negative discriminant: the ray passes the sphere by.
      if (bb < ac) return res;
      disc = bb - ac;
    end
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= disc) root = cand;
    end
    qmag = 65'(bmag) + 65'(root);
    qneg = !bneg;
    if (qmag == 0) begin
      // Tangent at the origin: both roots are zero.
      t0 = 0;
      t1 = 0;
    end else begin
      t0 = signed_root(qneg, (128'(qmag) << FRAC_BITS) / 128'(a));
      t1 = signed_root(cneg != qneg, (128'(cmag) << FRAC_BITS) / 128'(qmag));
    end
    if (t0 > t1) begin
      tt = t0; t0 = t1; t1 = tt;
    end
    if (t0 > tmax || t1 < tmin) return res;
    tt = t0;
    if (t0 < tmin) begin
      tt = t1;
      if (tt > tmax) return res;
    end
    res.hit = 1'b1;
    res.t_hit = fix_t'(tt);
    return res;
  endfunction

  // Monitor: radius writes, accepted rays, result checks and the watchdog.
  always @(posedge clk) begin
    hit_result_t exp_res;
    bit          active;
    if (rst_n) begin
      active = 1'b0;
      if (out_strobe) begin
        active = 1'b1;
        if (pending_hits.size() == 0) begin
          $display("%0t: unexpected result transaction hit=%b t_hit=%h",
                   $time, out_hit, out_t_hit);
          error_count = error_count + 1;
        end else begin
          exp_res = pending_hits.pop_front();
          if (out_hit !== exp_res.hit) begin
            $display("%0t: hit expected %b actual %b", $time, exp_res.hit, out_hit);
            error_count = error_count + 1;
          end
          if (out_t_hit !== exp_res.t_hit) begin
            $display("%0t: t_hit expected %h actual %h", $time, exp_res.t_hit, out_t_hit);
            error_count = error_count + 1;
          end
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        pending_hits.push_back(predict_intersection(ray_drv, radius_model));
      end
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        radius_model <= cfg_sphere_radius;
      end
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Send one ray, sometimes with a random idle burst ahead of it.
  task automatic send_ray(ray_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    ray_drv <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and let every outstanding ray leave the pipeline.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_hits.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_sphere_radius <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ray_t make_ray(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy,
                                    fix_t dz, fix_t tlo, fix_t thi);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
    r.rng.t_min = tlo;
    r.rng.t_max = thi;
    return r;
  endfunction

  // Coordinate mostly on the scale of the sphere, sometimes anywhere.
  function automatic fix_t pick_coord(longint scale);
    longint span;
    case ($urandom_range(0, 9))
      0, 1: return fix_t'($urandom);
      8:    return fix_t'(int'($urandom_range(0, 512)) - 256);
      9: begin
        case ($urandom_range(0, 2))
          0: return {1'b1, {(DATA_W-1){1'b0}}};
          1: return {1'b0, {(DATA_W-1){1'b1}}};
          default: return '0;
        endcase
      end
      default: begin
        span = 2 * scale + 65536;
        if (span > 64'sd2147483647) return fix_t'($urandom);
        return fix_t'(longint'($urandom_range(0, 32'(2 * span))) - span);
      end
    endcase
  endfunction

  function automatic ray_t random_ray(logic [RADIUS_W-1:0] rad);
    ray_t r;
    longint dscale;
    r.origin_x = pick_coord(rad);
    r.origin_y = pick_coord(rad);
    r.origin_z = pick_coord(rad);
    dscale = longint'(1) << $urandom_range(4, 22);
    r.dir_x = pick_coord(dscale);
    r.dir_y = pick_coord(dscale);
    r.dir_z = pick_coord(dscale);
    case ($urandom_range(0, 5))
      0: begin
        r.rng.t_min = fix_t'($urandom);
        r.rng.t_max = fix_t'($urandom);
      end
      1: begin
        r.rng.t_min = {1'b1, {(DATA_W-1){1'b0}}};
        r.rng.t_max = {1'b0, {(DATA_W-1){1'b1}}};
      end
      default: begin
        r.rng.t_min = fix_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        r.rng.t_max = fix_t'($urandom_range(0, 32'h7fff_ffff));
      end
    endcase
    return r;
  endfunction

  // Rays at the reset radius of 1.0, covering each special case.
  task automatic test_directed_cases();
    fix_t one, mx, mn;
    one = 32'sh0001_0000;
    mx  = {1'b0, {(DATA_W-1){1'b1}}};
    mn  = {1'b1, {(DATA_W-1){1'b0}}};
    // Zero direction.
    send_ray(make_ray(0, 0, 0, 0, 0, 0, mn, mx));
    // Straight hit from outside, and from inside the sphere.
    send_ray(make_ray(-3 * one, 0, 0, one, 0, 0, 0, mx));
    send_ray(make_ray(0, 0, 0, 0, one, 0, 0, mx));
    send_ray(make_ray(0, 0, 0, 0, 0, -one, mn, mx));
    // Negative discriminant: passes beside the sphere.
    send_ray(make_ray(-3 * one, 2 * one, 0, one, 0, 0, 0, mx));
    // Tangent at the origin: origin on the surface, direction along it.
    send_ray(make_ray(one, 0, 0, 0, one, 0, mn, mx));
    send_ray(make_ray(one, 0, 0, 0, one, 0, 1, mx));
    // Grazing tangent further along.
    send_ray(make_ray(-2 * one, one, 0, one, 0, 0, 0, mx));
    // Inverted range.
    send_ray(make_ray(-3 * one, 0, 0, one, 0, 0, mx, 0));
    // Near root below t_min, far root taken; both beyond range.
    send_ray(make_ray(-3 * one, 0, 0, one, 0, 0, 3 * one, mx));
    send_ray(make_ray(-3 * one, 0, 0, one, 0, 0, 5 * one, mx));
    send_ray(make_ray(-3 * one, 0, 0, one, 0, 0, 0, one));
    // Tiny directions make the roots saturate.
    send_ray(make_ray(-3 * one, 0, 0, 1, 0, 0, mn, mx));
    send_ray(make_ray(3 * one, 0, 0, 1, 0, 0, mn, mx));
    send_ray(make_ray(0, 0, 0, 1, 0, 0, mn, mx));
    // Field extremes.
    send_ray(make_ray(mx, mx, mx, mx, mx, mx, mx, mx));
    send_ray(make_ray(mn, mn, mn, mn, mn, mn, mn, mn));
    send_ray(make_ray(mn, mx, mn, mx, mn, mx, mn, mx));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
    send_ray(make_ray(mn, 0, 0, mx, 0, 0, mn, mx));
  endtask

  // Zero radius and full-scale radius.
  task automatic test_radius_extremes();
    write_radius('0);
    send_ray(make_ray(-32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0, 32'sh8000_0000,
                      32'sh7fff_ffff));
    send_ray(make_ray(0, 0, 0, 32'sh0001_0000, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    for (int i = 0; i < 200; i++) send_ray(random_ray(radius_model));
    write_radius({RADIUS_W{1'b1}});
    send_ray(make_ray(0, 0, 0, 32'sh0001_0000, 0, 0, 0, 32'sh7fff_ffff));
    send_ray(make_ray(32'sh8000_0000, 0, 0, 1, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    for (int i = 0; i < 200; i++) send_ray(random_ray(radius_model));
  endtask

  // Random rays under random radii and then the reset radius, the last phase without idling.
  task automatic test_random_rays();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_radius(RADIUS_W'($urandom_range(1 << 12, 1 << 20)));
        1: write_radius(RADIUS_W'($urandom));
        2: write_radius(RADIUS_W'($urandom_range(1, 1 << 8)));
        default: write_radius(RADIUS_RESET);
      endcase
      if (phase == 3) idle_on = 1'b0;
      for (int i = 0; i < 160; i++) send_ray(random_ray(radius_model));
    end
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    ray_drv = '0;
    cfg_valid = 1'b0;
    cfg_sphere_radius = '0;
    radius_model = RADIUS_RESET;
    error_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    for (int i = 0; i < 220; i++) send_ray(random_ray(radius_model));
    test_radius_extremes();
    test_random_rays();
    drain_pipeline();
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
